>>> src/bdl_pkg.sv
package bdl_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned PtrW     = $clog2(Capacity);
  localparam int unsigned CntW     = PtrW + 1;
  localparam int unsigned EntryW   = 24;

  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_RD_HEAD  = 3'd4,
    CMD_RD_TAIL  = 3'd5,
    CMD_RD_INDEX = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] pos_symbol;
    logic [7:0] position;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_x;
    logic [7:0] read_y;
    logic [7:0] read_symbol;
    logic [8:0] entry_count;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [PtrW-1:0]   addr;
    logic [EntryW-1:0] wdata;
  } mem_req_t;

endpackage

>>> src/bdl_ram.sv
module bdl_ram (
  input  logic                        clk_i,
  input  bdl_pkg::mem_req_t           req_i,
  output logic [bdl_pkg::EntryW-1:0]  rdata_o
);

  logic [bdl_pkg::EntryW-1:0] mem_q [bdl_pkg::Capacity];
  logic [bdl_pkg::EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bdl_ctrl.sv
module bdl_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  bdl_pkg::cmd_t              cmd_i,
  output bdl_pkg::mem_req_t          req_o,
  output logic                       done_o,
  output logic                       rd_ok_o,
  output bdl_pkg::status_e           status_o,
  output logic [bdl_pkg::CntW-1:0]   count_o
);

  logic [bdl_pkg::PtrW-1:0] head_q, head_d;
  logic [bdl_pkg::CntW-1:0] count_q, count_d;
  logic                     done_q, rd_ok_q, rd_ok_d;
  bdl_pkg::status_e         status_q, status_d;
  logic                     full, empty;
  logic [bdl_pkg::PtrW-1:0] tail, head_m1, head_p1, idx_addr, cnt_lo;

  assign full     = (count_q == bdl_pkg::CntW'(bdl_pkg::Capacity));
  assign empty    = (count_q == '0);
  assign cnt_lo   = count_q[bdl_pkg::PtrW-1:0];
  // ring arithmetic wraps naturally at a power-of-two capacity
  assign tail     = head_q + cnt_lo - bdl_pkg::PtrW'(1);
  assign head_m1  = head_q - bdl_pkg::PtrW'(1);
  assign head_p1  = head_q + bdl_pkg::PtrW'(1);
  assign idx_addr = head_q + bdl_pkg::PtrW'(cmd_i.position);

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    status_d    = bdl_pkg::ST_OK;
    rd_ok_d     = 1'b0;
    req_o.we    = 1'b0;
    req_o.re    = 1'b0;
    req_o.addr  = head_q;
    req_o.wdata = {cmd_i.pos_symbol, cmd_i.pos_y, cmd_i.pos_x};
    unique case (bdl_pkg::cmd_e'(cmd_i.cmd))
      bdl_pkg::CMD_INS_HEAD: begin
        if (full) begin
          status_d = bdl_pkg::ST_FULL;
        end else begin
          req_o.we   = accept_i;
          req_o.addr = head_m1;
          head_d     = head_m1;
          count_d    = count_q + bdl_pkg::CntW'(1);
        end
      end
      bdl_pkg::CMD_INS_TAIL: begin
        if (full) begin
          status_d = bdl_pkg::ST_FULL;
        end else begin
          req_o.we   = accept_i;
          req_o.addr = head_q + cnt_lo;
          count_d    = count_q + bdl_pkg::CntW'(1);
        end
      end
      bdl_pkg::CMD_REM_HEAD: begin
        if (empty) begin
          status_d = bdl_pkg::ST_EMPTY;
        end else begin
          head_d  = head_p1;
          count_d = count_q - bdl_pkg::CntW'(1);
        end
      end
      bdl_pkg::CMD_REM_TAIL: begin
        if (empty) begin
          status_d = bdl_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - bdl_pkg::CntW'(1);
        end
      end
      bdl_pkg::CMD_RD_HEAD: begin
        if (empty) begin
          status_d = bdl_pkg::ST_EMPTY;
        end else begin
          req_o.re = accept_i;
          rd_ok_d  = 1'b1;
        end
      end
      bdl_pkg::CMD_RD_TAIL: begin
        if (empty) begin
          status_d = bdl_pkg::ST_EMPTY;
        end else begin
          req_o.re   = accept_i;
          req_o.addr = tail;
          rd_ok_d    = 1'b1;
        end
      end
      bdl_pkg::CMD_RD_INDEX: begin
        if (bdl_pkg::CntW'(cmd_i.position) >= count_q) begin
          status_d = bdl_pkg::ST_RANGE;
        end else begin
          req_o.re   = accept_i;
          req_o.addr = idx_addr;
          rd_ok_d    = 1'b1;
        end
      end
      default: ;  // unused code: no-op, ok status
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      rd_ok_q  <= 1'b0;
      status_q <= bdl_pkg::ST_OK;
    end else begin
      done_q <= accept_i;
      if (accept_i) begin
        head_q   <= head_d;
        count_q  <= count_d;
        rd_ok_q  <= rd_ok_d;
        status_q <= status_d;
      end
    end
  end

  assign done_o   = done_q;
  assign rd_ok_o  = rd_ok_q;
  assign status_o = status_q;
  assign count_o  = count_q;

endmodule

>>> src/bounded_double_ended_list.sv
// Bounded double-ended list of (x, y, symbol) entries held in a ring store.
// Command channel: drive cmd_i and raise start; the command transfers at
// a rising edge with start high and busy low. busy stays low, so a
// command can be issued every cycle.
// Result channel: one result per command, shown on rsp_o for exactly one
// cycle with done_o high, in the cycle right after the command transfers.
// The result cannot be held off; a new command may transfer in
// the same cycle the previous result is shown.
// Throughput is one command per cycle: each command makes at most a single access
// to the 256 x 24 entry RAM (one write for inserts, one read for reads) and
// the head pointer and count update in that same cycle.
// Failed commands (insert when full, remove/read when empty, index past the
// end) report their status and leave the list unchanged. Read data fields
// are zero unless the command was a successful read.
// Reset empties the list (head and count cleared); RAM contents are not
// cleared, since no read can reach an entry that was never written.
module bounded_double_ended_list (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bdl_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          done_o,
  output bdl_pkg::rsp_t rsp_o
);

  logic                       accept;
  bdl_pkg::mem_req_t          req;
  logic [bdl_pkg::EntryW-1:0] rdata;
  logic                       rd_ok;
  bdl_pkg::status_e           status;
  logic [bdl_pkg::CntW-1:0]   count;

  // no command needs more than a single RAM access, so none is ever held off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  bdl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .req_o    (req),
    .done_o   (done_o),
    .rd_ok_o  (rd_ok),
    .status_o (status),
    .count_o  (count)
  );

  bdl_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  always_comb begin
    rsp_o.read_x      = rd_ok ? rdata[7:0]   : 8'd0;
    rsp_o.read_y      = rd_ok ? rdata[15:8]  : 8'd0;
    rsp_o.read_symbol = rd_ok ? rdata[23:16] : 8'd0;
    rsp_o.entry_count = 9'(count);
    rsp_o.status      = status;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result without a command transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= bdl_pkg::CntW'(bdl_pkg::Capacity))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status == bdl_pkg::ST_FULL) |->
      count == bdl_pkg::CntW'(bdl_pkg::Capacity))
    else $error("full status with room left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status == bdl_pkg::ST_EMPTY) |-> count == '0)
    else $error("empty status with entries present");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rd_ok) |-> (status == bdl_pkg::ST_OK && count != '0))
    else $error("read data returned from an empty list");

endmodule

>>> tb/testbench.sv
module testbench;
  import bdl_pkg::*;

  localparam logic [2:0] CmdUnused = 3'd7;
  localparam int unsigned RandomCmds = 1550;
  localparam int unsigned QuietFirst = 400;
  localparam int unsigned QuietLast  = 700;

  typedef struct {
    cmd_t c;
    bit   typed;
    rsp_t r;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  cmd_t cmd_i;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  // expectation typed into the directed table, sent along with the command
  logic typed_now;
  rsp_t typed_rsp;

  // shadow of the list: ring store, head pointer, entry count
  logic [23:0] ring_mem [Capacity];
  int unsigned ring_head = 0;
  int unsigned ring_cnt  = 0;

  rsp_t        pending_rsp_q [$];
  int unsigned err_cnt = 0;
  bit          quiet;
  dir_row_t    dir_rows [$];

  bounded_double_ended_list u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Applies one command to the shadow list and returns the result it gives.
  task automatic apply_list_cmd(input cmd_t c, output rsp_t r);
    logic [23:0] data;
    status_e     st;
    data = '0;
    st   = ST_OK;
    case (c.cmd)
      CMD_INS_HEAD: begin
        if (ring_cnt >= Capacity) begin
          st = ST_FULL;
        end else begin
          ring_head = (ring_head + Capacity - 1) % Capacity;
          ring_mem[ring_head] = {c.pos_symbol, c.pos_y, c.pos_x};
          ring_cnt++;
        end
      end
      CMD_INS_TAIL: begin
        if (ring_cnt >= Capacity) begin
          st = ST_FULL;
        end else begin
          ring_mem[(ring_head + ring_cnt) % Capacity] = {c.pos_symbol, c.pos_y, c.pos_x};
          ring_cnt++;
        end
      end
      CMD_REM_HEAD: begin
        if (ring_cnt == 0) begin
          st = ST_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % Capacity;
          ring_cnt--;
        end
      end
      CMD_REM_TAIL: begin
        if (ring_cnt == 0) st = ST_EMPTY;
        else ring_cnt--;
      end
      CMD_RD_HEAD: begin
        if (ring_cnt == 0) st = ST_EMPTY;
        else data = ring_mem[ring_head];
      end
      CMD_RD_TAIL: begin
        if (ring_cnt == 0) st = ST_EMPTY;
        else data = ring_mem[(ring_head + ring_cnt - 1) % Capacity];
      end
      CMD_RD_INDEX: begin
        if (c.position >= ring_cnt) st = ST_RANGE;
        else data = ring_mem[(ring_head + c.position) % Capacity];
      end
      default: ;
    endcase
    r.read_x      = data[7:0];
    r.read_y      = data[15:8];
    r.read_symbol = data[23:16];
    r.entry_count = 9'(ring_cnt);
    r.status      = st;
  endtask

  // Push on transfer first, then match the shown result against the oldest.
  always @(posedge clk_i) begin : rsp_check
    rsp_t pred;
    rsp_t want;
    if (rst_ni && start && !busy) begin
      apply_list_cmd(cmd_i, pred);
      pending_rsp_q.push_back(typed_now ? typed_rsp : pred);
    end
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("result with no command pending");
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("read_x", rsp_o.read_x, want.read_x);
        check_field("read_y", rsp_o.read_y, want.read_y);
        check_field("read_symbol", rsp_o.read_symbol, want.read_symbol);
        check_field("entry_count", rsp_o.entry_count, want.entry_count);
        check_field("status", rsp_o.status, want.status);
      end
    end
  end

  task automatic add_row(input logic [2:0] cmd, input logic [7:0] x, input logic [7:0] y,
                         input logic [7:0] s, input logic [7:0] pos, input bit typed,
                         input logic [7:0] rx, input logic [7:0] ry, input logic [7:0] rs,
                         input int cnt, input status_e st);
    dir_row_t row;
    row.c.cmd         = cmd;
    row.c.pos_x       = x;
    row.c.pos_y       = y;
    row.c.pos_symbol  = s;
    row.c.position    = pos;
    row.typed         = typed;
    row.r.read_x      = rx;
    row.r.read_y      = ry;
    row.r.read_symbol = rs;
    row.r.entry_count = 9'(cnt);
    row.r.status      = st;
    dir_rows.push_back(row);
  endtask

  task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t r);
    @(negedge clk_i);
    if (!quiet) begin
      while ($urandom_range(99) < 16) begin
        start = 1'b0;
        @(negedge clk_i);
      end
    end
    start     = 1'b1;
    cmd_i     = c;
    typed_now = typed;
    typed_rsp = r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // mode 0 leans toward filling, 1 toward draining, 2 is balanced
  function automatic cmd_t pick_cmd(input int mode);
    cmd_t c;
    int   p;
    int   ins_lim;
    int   rem_lim;
    p = $urandom_range(99);
    ins_lim = (mode == 0) ? 60 : (mode == 1) ? 15 : 32;
    rem_lim = ins_lim + ((mode == 0) ? 15 : (mode == 1) ? 55 : 30);
    c.pos_x      = 8'($urandom_range(255));
    c.pos_y      = 8'($urandom_range(255));
    c.pos_symbol = 8'($urandom_range(255));
    if (ring_cnt > 0 && $urandom_range(3) != 0) c.position = 8'($urandom_range(ring_cnt - 1));
    else c.position = 8'($urandom_range(255));
    if (p < ins_lim) c.cmd = $urandom_range(1) ? CMD_INS_TAIL : CMD_INS_HEAD;
    else if (p < rem_lim) c.cmd = $urandom_range(1) ? CMD_REM_TAIL : CMD_REM_HEAD;
    else if (p < 97) begin
      case ($urandom_range(2))
        0:       c.cmd = CMD_RD_HEAD;
        1:       c.cmd = CMD_RD_TAIL;
        default: c.cmd = CMD_RD_INDEX;
      endcase
    end else c.cmd = CmdUnused;
    return c;
  endfunction

  initial begin : stim
    cmd_t        c;
    rsp_t        none;
    int unsigned n;
    int unsigned seg_len;
    int          mode;
    rst_ni    = 1'b0;
    start     = 1'b0;
    cmd_i     = '0;
    typed_now = 1'b0;
    typed_rsp = '0;
    none      = '0;
    quiet     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    //      cmd           x      y      s      pos    typed rx     ry     rs     cnt status
    add_row(CMD_RD_HEAD,  8'h11, 8'h22, 8'h33, 8'h00, 1, 8'h00, 8'h00, 8'h00, 0, ST_EMPTY);
    add_row(CMD_RD_TAIL,  8'h00, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 0, ST_EMPTY);
    add_row(CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 0, ST_EMPTY);
    add_row(CMD_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 0, ST_EMPTY);
    add_row(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 0, ST_RANGE);
    add_row(CmdUnused,    8'hff, 8'hff, 8'hff, 8'hff, 1, 8'h00, 8'h00, 8'h00, 0, ST_OK);
    add_row(CMD_INS_TAIL, 8'hff, 8'hff, 8'hff, 8'h00, 1, 8'h00, 8'h00, 8'h00, 1, ST_OK);
    add_row(CMD_INS_HEAD, 8'h00, 8'h00, 8'h00, 8'hff, 1, 8'h00, 8'h00, 8'h00, 2, ST_OK);
    add_row(CMD_RD_HEAD,  8'h00, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 2, ST_OK);
    add_row(CMD_RD_TAIL,  8'h00, 8'h00, 8'h00, 8'h00, 1, 8'hff, 8'hff, 8'hff, 2, ST_OK);
    add_row(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h01, 1, 8'hff, 8'hff, 8'hff, 2, ST_OK);
    add_row(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h02, 1, 8'h00, 8'h00, 8'h00, 2, ST_RANGE);
    add_row(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'hff, 1, 8'h00, 8'h00, 8'h00, 2, ST_RANGE);
    add_row(CMD_INS_HEAD, 8'ha5, 8'h5a, 8'h3c, 8'h00, 0, 8'h00, 8'h00, 8'h00, 0, ST_OK);
    add_row(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'h00, 0, ST_OK);
    add_row(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h02, 0, 8'h00, 8'h00, 8'h00, 0, ST_OK);
    add_row(CMD_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 2, ST_OK);
    add_row(CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 1, ST_OK);
    add_row(CMD_RD_HEAD,  8'h00, 8'h00, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'h00, 0, ST_OK);

    foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);

    // fill to capacity, then poke the full list at its edges
    while (ring_cnt < Capacity) begin
      c     = pick_cmd(0);
      c.cmd = $urandom_range(1) ? CMD_INS_TAIL : CMD_INS_HEAD;
      send_cmd(c, 1'b0, none);
    end
    c = pick_cmd(0);
    c.cmd = CMD_INS_HEAD;
    send_cmd(c, 1'b0, none);
    c.cmd = CMD_INS_TAIL;
    send_cmd(c, 1'b0, none);
    c.cmd = CMD_RD_INDEX;
    c.position = 8'hff;
    send_cmd(c, 1'b0, none);
    c.cmd = CMD_RD_TAIL;
    send_cmd(c, 1'b0, none);

    n = 0;
    while (n < RandomCmds) begin
      seg_len = $urandom_range(300, 40);
      if (ring_cnt == Capacity) mode = 1;
      else if (ring_cnt == 0) mode = 0;
      else mode = $urandom_range(2);
      for (int j = 0; j < seg_len && n < RandomCmds; j++) begin
        quiet = (n >= QuietFirst && n < QuietLast);
        send_cmd(pick_cmd(mode), 1'b0, none);
        n++;
      end
    end

    @(negedge clk_i);
    start     = 1'b0;
    typed_now = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bdl_pkg.sv
src/bdl_ram.sv
src/bdl_ctrl.sv
src/bounded_double_ended_list.sv
tb/testbench.sv
